// File: rtl/core/aebd_pkg.sv
// Shared types and constants for the audio energy beat detector.
// No dependencies; imported by aebd_ctrl, aebd_dpath and the top level.
package aebd_pkg;

	localparam int FRAME_MAX  = 1024;
	localparam int SAMPLE_W   = 16;
	localparam int ENERGY_W   = 31;
	localparam int RATIO_W    = 8;
	localparam int ALPHA_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = ENERGY_W;

	// one squared sample is at most 2^30, two per pair
	localparam int SQ_W      = 2 * SAMPLE_W - 1;
	localparam int COUNT_W   = $clog2(FRAME_MAX + 1);
	localparam int SUM_W     = SQ_W + 1 + $clog2(FRAME_MAX);
	localparam int DIVISOR_W = COUNT_W + 1;
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// shared multiplier: 31 x 17 unsigned
	localparam int MUL_B_W = ALPHA_W + 1;
	localparam int PROD_W  = ENERGY_W + MUL_B_W;
	localparam int ALPHA_ONE = 1 << ALPHA_W;
	localparam int ROUND_HALF = 1 << (ALPHA_W - 1);

	localparam logic [ENERGY_W-1:0] MIN_ENERGY_RST   = ENERGY_W'(1073742);
	localparam logic [RATIO_W-1:0]  BEAT_RATIO_RST   = RATIO_W'(32);
	localparam logic [ALPHA_W-1:0]  SMOOTH_ALPHA_RST = ALPHA_W'(3277);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_ENERGY   = 2'd0,
		REG_BEAT_RATIO   = 2'd1,
		REG_SMOOTH_ALPHA = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_AVG_KEEP = 2'd0, // avg * (1 - alpha)
		MUL_NEW_WGT  = 2'd1, // energy * alpha
		MUL_RATIO    = 2'd2  // avg * beat_ratio
	} mul_sel_t;

	typedef struct packed {
		logic     accum;
		logic     div_load;
		logic     div_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_load;
		logic     sum_add;
		logic     finish;
	} aebd_cmd_t;

endpackage

// File: rtl/core/aebd_ctrl.sv
// Sequencer for the beat detector: handshakes, divide loop and multiply steps.
// Depends on aebd_pkg; drives aebd_dpath through aebd_cmd_t.
module aebd_ctrl import aebd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      frame_end,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output aebd_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_LOAD,
		ST_DIV,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 in_acc;
	logic                 out_acc;
	logic                 fin_go;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	// result register frees up in the same cycle it is taken
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_AVG_KEEP;
		cmd.accum    = in_acc;
		cmd.div_load = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = fin_go;
		unique case (state_q)
			ST_M0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AVG_KEEP;
			end
			ST_M1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_NEW_WGT;
				cmd.sum_load = 1'b1;
			end
			ST_M2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RATIO;
				cmd.sum_add = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && frame_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_LOAD;
				ST_LOAD: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_M0;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result overwritten while still pending");

	a_rose_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result raised without a finish step");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_M0) |-> ($past(state_q) == ST_DIV &&
			$past(div_cnt_q) == DIV_CNT_W'(DIV_STEPS - 1)))
		else $error("divide loop ended early");

endmodule

// File: rtl/core/aebd_dpath.sv
// Datapath: config registers, square accumulator, radix-2 divider,
// shared multiplier, smoothing and beat decision. Depends on aebd_pkg.
module aebd_dpath import aebd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  aebd_cmd_t                  cmd,
	output logic                       beat_found,
	output logic [ENERGY_W-1:0]        frame_energy,
	output logic [ENERGY_W-1:0]        average_energy
);

	logic [ENERGY_W-1:0]  min_energy_q;
	logic [RATIO_W-1:0]   beat_ratio_q;
	logic [ALPHA_W-1:0]   smooth_alpha_q;

	logic [COUNT_W-1:0]   count_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 acc_s1;
	logic [SQ_W-1:0]      sq_l_s1;
	logic [SQ_W-1:0]      sq_r_s1;
	logic [ENERGY_W-1:0]  smoothed_q;
	logic                 last_beat_q;

	logic [DIVISOR_W-1:0] divisor_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [SUM_W-1:0]     dq_q;

	logic [PROD_W-1:0]    prod_q;
	logic [PROD_W-1:0]    acc_q;

	logic                 beat_q;
	logic [ENERGY_W-1:0]  energy_out_q;
	logic [ENERGY_W-1:0]  avg_out_q;

	logic signed [2*SAMPLE_W-1:0] sq_l;
	logic signed [2*SAMPLE_W-1:0] sq_r;
	logic [DIVISOR_W:0]   trial;
	logic                 q_bit;
	logic [ENERGY_W-1:0]  energy;
	logic [MUL_B_W-1:0]   inv_alpha;
	logic [ENERGY_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [PROD_W-1:0]    mul_p;
	logic                 beat;
	logic [ENERGY_W-1:0]  next_avg;

	assign sq_l = left_sample * left_sample;
	assign sq_r = right_sample * right_sample;

	// restoring divide, one quotient bit per cycle; dividend shifts out the top
	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign q_bit = (trial >= {1'b0, divisor_q});
	// mean energy is at most 2^30, upper quotient bits are zero
	assign energy = dq_q[ENERGY_W-1:0];

	assign inv_alpha = MUL_B_W'(ALPHA_ONE) - {1'b0, smooth_alpha_q};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_AVG_KEEP: begin
				mul_a = smoothed_q;
				mul_b = inv_alpha;
			end
			MUL_NEW_WGT: begin
				mul_a = energy;
				mul_b = {1'b0, smooth_alpha_q};
			end
			MUL_RATIO: begin
				mul_a = smoothed_q;
				mul_b = MUL_B_W'(beat_ratio_q);
			end
			default: begin
				mul_a = smoothed_q;
				mul_b = inv_alpha;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// prod_q holds avg * ratio in the finish step; ratio is Q4.4
	assign beat = (PROD_W'({energy, 4'b0000}) > prod_q) &&
		(energy > min_energy_q) && !last_beat_q;
	assign next_avg = acc_q[ALPHA_W +: ENERGY_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_energy_q   <= MIN_ENERGY_RST;
			beat_ratio_q   <= BEAT_RATIO_RST;
			smooth_alpha_q <= SMOOTH_ALPHA_RST;
			count_q        <= '0;
			sum_q          <= '0;
			acc_s1         <= 1'b0;
			smoothed_q     <= '0;
			last_beat_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_MIN_ENERGY:   min_energy_q   <= cfg_data;
					REG_BEAT_RATIO:   beat_ratio_q   <= cfg_data[RATIO_W-1:0];
					REG_SMOOTH_ALPHA: smooth_alpha_q <= cfg_data[ALPHA_W-1:0];
					default: begin
					end
				endcase
			end
			// pairs beyond the frame limit are dropped
			acc_s1 <= cmd.accum && (count_q < COUNT_W'(FRAME_MAX));
			if (cmd.div_load) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				if (cmd.accum && (count_q < COUNT_W'(FRAME_MAX))) begin
					count_q <= count_q + 1'b1;
				end
				if (acc_s1) begin
					sum_q <= sum_q + SUM_W'(sq_l_s1) + SUM_W'(sq_r_s1);
				end
			end
			if (cmd.finish) begin
				smoothed_q  <= next_avg;
				last_beat_q <= beat;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_l_s1 <= sq_l[SQ_W-1:0];
		sq_r_s1 <= sq_r[SQ_W-1:0];
		if (cmd.div_load) begin
			divisor_q <= {count_q, 1'b0};
			rem_q     <= '0;
			dq_q      <= sum_q;
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? DIVISOR_W'(trial - {1'b0, divisor_q}) : trial[DIVISOR_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], q_bit};
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.sum_load) begin
			acc_q <= prod_q;
		end else if (cmd.sum_add) begin
			acc_q <= acc_q + prod_q + PROD_W'(ROUND_HALF);
		end
		if (cmd.finish) begin
			beat_q       <= beat;
			energy_out_q <= energy;
			avg_out_q    <= next_avg;
		end
	end

	assign beat_found     = beat_q;
	assign frame_energy   = energy_out_q;
	assign average_energy = avg_out_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(FRAME_MAX))
		else $error("pair count past frame limit");

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> (!acc_s1 && count_q != '0))
		else $error("divide started with pending add or empty frame");

endmodule

// File: rtl/core/audio_energy_beat_detector.sv
// Top level of the energy beat detector: joins sequencer and datapath.
// Depends on aebd_pkg, aebd_ctrl, aebd_dpath.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | left_sample, right_sample, frame_end
//  out     | out_valid/out_stall| beat_found, frame_energy, average_energy
//  cfg     | cfg_write          | cfg_index, cfg_data
//
// Each pair without frame_end has its squares added to the sum in the next cycle.
// A frame end runs its own transaction, drain, divider load, 42 divide steps
// (one quotient bit per cycle), three steps on the one shared 31x17 multiplier
// and a finish step.
// in_stall is high from the frame end transaction until the result is registered.
// The result register holds while out_stall is high; a new frame may fill up
// behind it and waits in its last step only if the old result is still pending.
// arst_n clears frame sums, smoothed energy and beat history, and resets config.
module audio_energy_beat_detector import aebd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       frame_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       beat_found,
	output logic [ENERGY_W-1:0]        frame_energy,
	output logic [ENERGY_W-1:0]        average_energy,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	aebd_cmd_t cmd;

	aebd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.frame_end (frame_end),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	aebd_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.cmd            (cmd),
		.beat_found     (beat_found),
		.frame_energy   (frame_energy),
		.average_energy (average_energy)
	);

endmodule
